// ===== rtl/core/cisd_pkg.sv =====
// package with formats, escape codes and decoder state type for the integer stream decoder
`timescale 1ns / 1ps
`default_nettype none
package cisd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 3;

  typedef enum logic {
    FMT_SIGNED = 1'b0,
    FMT_GROUP  = 1'b1
  } fmt_t;

  localparam logic [ByteW-1:0] ESC_HALF = 8'h80;
  localparam logic [ByteW-1:0] ESC_WORD = 8'h81;

  localparam logic [CountW-1:0] CNT_IDLE  = 3'd0;
  localparam logic [CountW-1:0] CNT_ONE   = 3'd1;
  localparam logic [CountW-1:0] CNT_TWO   = 3'd2;
  localparam logic [CountW-1:0] CNT_THREE = 3'd3;
  localparam logic [CountW-1:0] CNT_FOUR  = 3'd4;
  localparam logic [CountW-1:0] CNT_FIVE  = 3'd5;

  typedef struct packed {
    logic [CountW-1:0] bytes_seen;
    fmt_t              active_format;
    logic              wide_escape;
    logic [ValueW-1:0] accumulator;
  } dec_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/compact_integer_stream_decoder.sv =====
// top level of the compact integer stream decoder
//
//  channel | ports                                      | dir | handshake
//  --------+--------------------------------------------+-----+-----------
//  input   | in_data_byte[7:0], in_mode                 | in  | in_valid / in_ready
//  result  | out_value[31:0], out_byte_count[2:0],      | out | out_valid / out_ready
//          | out_format                                 |     |
//
// one byte per cycle while the result register is not stalled; a byte is first registered in the
// input register and its result, if any, is then registered in the result register
// the input register refills in the same cycle it drains, so back-to-back bytes stream
// a stalled result register holds the input register, and in_ready drops once both are full
// synchronous active-low reset clears the valid flags and the decoder state
`timescale 1ns / 1ps
`default_nettype none
module compact_integer_stream_decoder
  import cisd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ByteW-1:0]  in_data_byte,
  input  wire logic              in_mode,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [ValueW-1:0] out_value,
  output logic [CountW-1:0]      out_byte_count,
  output logic                   out_format
);

  logic              in_vld_r;
  logic [ByteW-1:0]  byte_r;
  logic              mode_r;
  logic              out_vld_r, out_vld_nxt;
  logic [ValueW-1:0] value_r, value_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  fmt_t              fmt_r, fmt_nxt;
  dec_state_t        st_r, st_nxt;

  logic              advance;
  logic              process;
  logic              emit;
  logic [CountW-1:0] seen_inc;
  logic [ValueW-1:0] acc_add;
  logic [ValueW-1:0] last_group;

  assign advance  = !out_vld_r || out_ready;
  assign process  = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;
  assign seen_inc = st_r.bytes_seen + CNT_ONE;

  always_comb begin
    acc_add    = '0;
    last_group = '0;
    case (st_r.bytes_seen[1:0])
      2'd1:    acc_add = {24'b0, byte_r};
      2'd2:    acc_add = {16'b0, byte_r, 8'b0};
      2'd3:    acc_add = {8'b0, byte_r, 16'b0};
      default: acc_add = {byte_r, 24'b0};
    endcase
    if (st_r.active_format == FMT_GROUP) begin
      case (st_r.bytes_seen[1:0])
        2'd1:    acc_add = {18'b0, byte_r[6:0], 7'b0};
        2'd2:    acc_add = {11'b0, byte_r[6:0], 14'b0};
        default: acc_add = '0;
      endcase
    end
    last_group = st_r.accumulator | {3'b0, byte_r, 21'b0};
    if (last_group[28]) begin
      last_group[31:29] = 3'b111;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    emit      = 1'b0;
    value_nxt = value_r;
    count_nxt = count_r;
    fmt_nxt   = fmt_r;
    if (st_r.bytes_seen == CNT_IDLE) begin
      if (mode_r == FMT_SIGNED) begin
        if (byte_r == ESC_HALF || byte_r == ESC_WORD) begin
          st_nxt.bytes_seen    = CNT_ONE;
          st_nxt.active_format = FMT_SIGNED;
          st_nxt.wide_escape   = byte_r[0];
          st_nxt.accumulator   = '0;
        end else begin
          emit      = 1'b1;
          value_nxt = {{24{byte_r[7]}}, byte_r};
          count_nxt = CNT_ONE;
          fmt_nxt   = FMT_SIGNED;
        end
      end else begin
        if (byte_r[7]) begin
          st_nxt.bytes_seen    = CNT_ONE;
          st_nxt.active_format = FMT_GROUP;
          st_nxt.wide_escape   = 1'b0;
          st_nxt.accumulator   = {25'b0, byte_r[6:0]};
        end else begin
          emit      = 1'b1;
          value_nxt = {24'b0, byte_r};
          count_nxt = CNT_ONE;
          fmt_nxt   = FMT_GROUP;
        end
      end
    end else if (st_r.active_format == FMT_SIGNED) begin
      st_nxt.accumulator = st_r.accumulator | acc_add;
      st_nxt.bytes_seen  = seen_inc;
      if (!st_r.wide_escape && seen_inc == CNT_THREE) begin
        emit      = 1'b1;
        value_nxt = {{16{st_nxt.accumulator[15]}}, st_nxt.accumulator[15:0]};
        count_nxt = CNT_THREE;
        fmt_nxt   = FMT_SIGNED;
      end else if (st_r.wide_escape && seen_inc == CNT_FIVE) begin
        emit      = 1'b1;
        value_nxt = st_nxt.accumulator;
        count_nxt = CNT_FIVE;
        fmt_nxt   = FMT_SIGNED;
      end
    end else begin
      if (st_r.bytes_seen >= CNT_THREE) begin
        emit      = 1'b1;
        value_nxt = last_group;
        count_nxt = CNT_FOUR;
        fmt_nxt   = FMT_GROUP;
      end else begin
        st_nxt.accumulator = st_r.accumulator | acc_add;
        st_nxt.bytes_seen  = seen_inc;
        if (!byte_r[7]) begin
          emit      = 1'b1;
          value_nxt = st_nxt.accumulator;
          count_nxt = seen_inc;
          fmt_nxt   = FMT_GROUP;
        end
      end
    end
    if (emit) begin
      st_nxt = '{bytes_seen: CNT_IDLE, active_format: FMT_SIGNED,
                 wide_escape: 1'b0, accumulator: '0};
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = process && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '{bytes_seen: CNT_IDLE, active_format: FMT_SIGNED,
                     wide_escape: 1'b0, accumulator: '0};
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
      if (process) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      mode_r <= in_mode;
    end
    if (process && emit) begin
      value_r <= value_nxt;
      count_r <= count_nxt;
      fmt_r   <= fmt_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_value      = value_r;
  assign out_byte_count = count_r;
  assign out_format     = fmt_r;

`ifndef SYNTHESIS
  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bytes_seen <= CNT_FOUR)
    else $error("bytes_seen out of range");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bytes_seen == CNT_IDLE |-> st_r.accumulator == '0 && !st_r.wide_escape)
    else $error("idle decoder holds stale state");

  a_group_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.active_format == FMT_GROUP |-> !st_r.wide_escape
      && st_r.bytes_seen <= CNT_THREE)
    else $error("group value in escape state");

  a_signed_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && fmt_r == FMT_SIGNED |->
      count_r == CNT_ONE || count_r == CNT_THREE || count_r == CNT_FIVE)
    else $error("bad byte count for signed format");

  a_group_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && fmt_r == FMT_GROUP |-> count_r != CNT_IDLE && count_r <= CNT_FOUR)
    else $error("bad byte count for group format");
`endif

endmodule
`default_nettype wire
